// ----- sv/adsr_pkg.sv -----
`default_nettype none

package adsr_pkg;

    localparam int LevelW    = 32;
    localparam int PeakW     = 29;
    localparam int GainW     = 17;
    localparam int FracW     = 28;
    localparam int GainFracW = 16;
    localparam int ProdW     = 2 * LevelW;
    localparam int ShiftW    = ProdW - FracW;
    localparam int SumW      = ShiftW + 1;
    localparam int SusProdW  = PeakW + GainW;
    localparam int SusW      = SusProdW - GainFracW;
    localparam int AddrW     = 3;
    localparam int DataW     = 32;

    localparam logic [GainW-1:0] GainReset = 17'd65536;
    localparam logic [AddrW-3:0] RegSustainGain = 1'b0;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_NOTE_ON = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_KILL    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef struct packed {
        mode_t                    mode;
        logic [PeakW-1:0]         peak_level;
        logic signed [LevelW-1:0] first_offset;
        logic signed [LevelW-1:0] first_factor;
        logic signed [LevelW-1:0] second_offset;
        logic signed [LevelW-1:0] second_factor;
    } cmd_t;

    typedef struct packed {
        logic signed [LevelW-1:0] envelope_level;
        phase_t                   phase_code;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/adsr_cmd_if.sv -----
`default_nettype none

interface adsr_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [28:0]        peak_level;
    logic signed [31:0] first_offset;
    logic signed [31:0] first_factor;
    logic signed [31:0] second_offset;
    logic signed [31:0] second_factor;

    modport source (
        output valid, mode, peak_level, first_offset, first_factor,
               second_offset, second_factor,
        input  ready
    );

    modport sink (
        input  valid, mode, peak_level, first_offset, first_factor,
               second_offset, second_factor,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/adsr_env_if.sv -----
`default_nettype none

interface adsr_env_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] envelope_level;
    logic [2:0]         phase_code;

    modport source (
        output valid, envelope_level, phase_code,
        input  ready
    );

    modport sink (
        input  valid, envelope_level, phase_code,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/adsr_apb_regs.sv -----
`default_nettype none

module adsr_apb_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [adsr_pkg::AddrW-1:0]    paddr,
    input  wire logic [adsr_pkg::DataW-1:0]    pwdata,
    output logic      [adsr_pkg::DataW-1:0]    prdata,
    output logic                               pready,
    output logic      [adsr_pkg::GainW-1:0]    sustain_gain
);

    logic [adsr_pkg::GainW-1:0] gain_reg;
    logic [adsr_pkg::GainW-1:0] gain_next;
    logic                       hit;

    // word index sits above the byte offset
    assign hit    = (paddr[adsr_pkg::AddrW-1:2] == adsr_pkg::RegSustainGain);
    assign pready = 1'b1;

    always_comb
    begin
        gain_next = gain_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            gain_next = pwdata[adsr_pkg::GainW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= adsr_pkg::GainReset;
        end
        else
        begin
            gain_reg <= gain_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = {{(adsr_pkg::DataW - adsr_pkg::GainW){1'b0}}, gain_reg};
        end
    end

    assign sustain_gain = gain_reg;

endmodule

`default_nettype wire

// ----- sv/adsr_recur.sv -----
`default_nettype none

module adsr_recur (
    input  wire logic signed [adsr_pkg::LevelW-1:0] level,
    input  wire logic signed [adsr_pkg::LevelW-1:0] offset,
    input  wire logic signed [adsr_pkg::LevelW-1:0] factor,
    output logic signed      [adsr_pkg::LevelW-1:0] result
);

    logic signed [adsr_pkg::ProdW-1:0]  prod;
    logic signed [adsr_pkg::ShiftW-1:0] scaled;
    logic signed [adsr_pkg::SumW-1:0]   sum;
    logic                               all_same;

    assign prod = level * factor;
    // dropping the low bits of a two's complement value rounds toward minus infinity
    assign scaled = prod[adsr_pkg::ProdW-1:adsr_pkg::FracW];
    assign sum = {{(adsr_pkg::SumW - adsr_pkg::LevelW){offset[adsr_pkg::LevelW-1]}}, offset}
               + {scaled[adsr_pkg::ShiftW-1], scaled};

    assign all_same = (sum[adsr_pkg::SumW-1:adsr_pkg::LevelW-1] == '0)
                   || (sum[adsr_pkg::SumW-1:adsr_pkg::LevelW-1] == '1);

    always_comb
    begin
        if (all_same)
        begin
            result = sum[adsr_pkg::LevelW-1:0];
        end
        else if (sum[adsr_pkg::SumW-1])
        begin
            result = {1'b1, {(adsr_pkg::LevelW-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(adsr_pkg::LevelW-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

// ----- sv/adsr_core.sv -----
`default_nettype none

module adsr_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire adsr_pkg::cmd_t              cmd,
    input  wire logic [adsr_pkg::GainW-1:0]  sustain_gain,
    output adsr_pkg::result_t                res
);

    localparam int LW = adsr_pkg::LevelW;
    localparam int PW = adsr_pkg::PeakW;

    logic signed [LW-1:0] level_reg, level_next;
    adsr_pkg::phase_t     phase_reg, phase_next;
    logic [PW-1:0]        peak_reg, peak_next;
    logic [PW-1:0]        sustain_reg, sustain_next;
    logic signed [LW-1:0] att_off_reg, att_off_next;
    logic signed [LW-1:0] att_fac_reg, att_fac_next;
    logic signed [LW-1:0] dec_off_reg, dec_off_next;
    logic signed [LW-1:0] dec_fac_reg, dec_fac_next;
    logic signed [LW-1:0] rel_off_reg, rel_off_next;
    logic signed [LW-1:0] rel_fac_reg, rel_fac_next;

    logic signed [LW-1:0]             sel_off;
    logic signed [LW-1:0]             sel_fac;
    logic signed [LW-1:0]             stepped;
    logic [adsr_pkg::SusProdW-1:0]    sus_prod;
    logic [adsr_pkg::SusW-1:0]        sus_scaled;
    logic [PW-1:0]                    sus_sat;
    logic signed [LW-1:0]             peak_s;
    logic signed [LW-1:0]             sustain_s;

    // one multiply-add shared by attack, decay and release
    always_comb
    begin
        unique case (phase_reg)
            adsr_pkg::PH_ATTACK:
            begin
                sel_off = att_off_reg;
                sel_fac = att_fac_reg;
            end
            adsr_pkg::PH_DECAY:
            begin
                sel_off = dec_off_reg;
                sel_fac = dec_fac_reg;
            end
            default:
            begin
                sel_off = rel_off_reg;
                sel_fac = rel_fac_reg;
            end
        endcase
    end

    adsr_recur u_recur (
        .level  (level_reg),
        .offset (sel_off),
        .factor (sel_fac),
        .result (stepped)
    );

    // sustain target taken from the gain at note-on time
    assign sus_prod   = cmd.peak_level * sustain_gain;
    assign sus_scaled = sus_prod[adsr_pkg::SusProdW-1:adsr_pkg::GainFracW];
    assign sus_sat    = sus_scaled[adsr_pkg::SusW-1] ? {PW{1'b1}} : sus_scaled[PW-1:0];

    assign peak_s    = $signed({{(LW - PW){1'b0}}, peak_reg});
    assign sustain_s = $signed({{(LW - PW){1'b0}}, sustain_reg});

    always_comb
    begin
        level_next   = level_reg;
        phase_next   = phase_reg;
        peak_next    = peak_reg;
        sustain_next = sustain_reg;
        att_off_next = att_off_reg;
        att_fac_next = att_fac_reg;
        dec_off_next = dec_off_reg;
        dec_fac_next = dec_fac_reg;
        rel_off_next = rel_off_reg;
        rel_fac_next = rel_fac_reg;

        unique case (cmd.mode)
            adsr_pkg::MODE_NOTE_ON:
            begin
                peak_next    = cmd.peak_level;
                sustain_next = sus_sat;
                att_off_next = cmd.first_offset;
                att_fac_next = cmd.first_factor;
                dec_off_next = cmd.second_offset;
                dec_fac_next = cmd.second_factor;
                phase_next   = adsr_pkg::PH_ATTACK;
            end
            adsr_pkg::MODE_RELEASE:
            begin
                rel_off_next = cmd.first_offset;
                rel_fac_next = cmd.first_factor;
                phase_next   = adsr_pkg::PH_RELEASE;
            end
            adsr_pkg::MODE_KILL:
            begin
                level_next = '0;
                phase_next = adsr_pkg::PH_IDLE;
            end
            adsr_pkg::MODE_TICK:
            begin
                unique case (phase_reg)
                    adsr_pkg::PH_ATTACK:
                    begin
                        if (stepped >= peak_s)
                        begin
                            level_next = peak_s;
                            phase_next = adsr_pkg::PH_DECAY;
                        end
                        else
                        begin
                            level_next = stepped;
                        end
                    end
                    adsr_pkg::PH_DECAY:
                    begin
                        if (stepped <= sustain_s)
                        begin
                            level_next = sustain_s;
                            phase_next = adsr_pkg::PH_SUSTAIN;
                        end
                        else
                        begin
                            level_next = stepped;
                        end
                    end
                    adsr_pkg::PH_RELEASE:
                    begin
                        if (stepped <= $signed({LW{1'b0}}))
                        begin
                            level_next = '0;
                            phase_next = adsr_pkg::PH_IDLE;
                        end
                        else
                        begin
                            level_next = stepped;
                        end
                    end
                    default:
                    begin
                        level_next = level_reg;
                    end
                endcase
            end
            default:
            begin
                level_next = level_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= '0;
            phase_reg   <= adsr_pkg::PH_IDLE;
            peak_reg    <= '0;
            sustain_reg <= '0;
            att_off_reg <= '0;
            att_fac_reg <= '0;
            dec_off_reg <= '0;
            dec_fac_reg <= '0;
            rel_off_reg <= '0;
            rel_fac_reg <= '0;
        end
        else if (advance)
        begin
            level_reg   <= level_next;
            phase_reg   <= phase_next;
            peak_reg    <= peak_next;
            sustain_reg <= sustain_next;
            att_off_reg <= att_off_next;
            att_fac_reg <= att_fac_next;
            dec_off_reg <= dec_off_next;
            dec_fac_reg <= dec_fac_next;
            rel_off_reg <= rel_off_next;
            rel_fac_reg <= rel_fac_next;
        end
    end

    assign res.envelope_level = level_next;
    assign res.phase_code     = phase_next;

endmodule

`default_nettype wire

// ----- sv/adsr_envelope_stepper_top.sv -----
`default_nettype none

// channel  direction  handshake          payload
// cmd      in         valid/ready        mode, peak_level, offsets, factors
// env      out        valid/ready        envelope_level, phase_code
// apb      in         psel/penable       sustain_gain at byte address 0
//
// one item per cycle sustained while env is ready; a command is held in the command
// register, and its result is registered in the result register before it is offered
// the cycle is set by the 32x32 multiply, add and saturate of the level update
// a waiting result holds the command register, so with both registers full the
// command side stalls until the result leaves
// async active-low reset returns the envelope to idle at zero, gain to 1.0

module adsr_envelope_stepper_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    adsr_cmd_if.sink                         cmd,
    adsr_env_if.source                       env,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [adsr_pkg::AddrW-1:0]  paddr,
    input  wire logic [adsr_pkg::DataW-1:0]  pwdata,
    output logic      [adsr_pkg::DataW-1:0]  prdata,
    output logic                             pready
);

    logic                       in_valid_reg, in_valid_next;
    adsr_pkg::cmd_t             cmd_reg;
    adsr_pkg::cmd_t             cmd_in;
    logic                       out_valid_reg, out_valid_next;
    adsr_pkg::result_t          res_reg;
    adsr_pkg::result_t          res_calc;
    logic                       advance;
    logic                       take;
    logic [adsr_pkg::GainW-1:0] sustain_gain;

    adsr_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sustain_gain (sustain_gain)
    );

    assign cmd_in.mode          = adsr_pkg::mode_t'(cmd.mode);
    assign cmd_in.peak_level    = cmd.peak_level;
    assign cmd_in.first_offset  = cmd.first_offset;
    assign cmd_in.first_factor  = cmd.first_factor;
    assign cmd_in.second_offset = cmd.second_offset;
    assign cmd_in.second_factor = cmd.second_factor;

    // the held command moves on once the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || env.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    adsr_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .cmd          (cmd_reg),
        .sustain_gain (sustain_gain),
        .res          (res_calc)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (env.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_in;
        end
        if (advance)
        begin
            res_reg <= res_calc;
        end
    end

    assign env.valid          = out_valid_reg;
    assign env.envelope_level = res_reg.envelope_level;
    assign env.phase_code     = res_reg.phase_code;

`ifndef SYNTHESIS
    // an idle result always carries a zero level
    a_idle_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (env.valid && (env.phase_code == adsr_pkg::PH_IDLE)) |-> (env.envelope_level == '0))
        else $error("idle result with non-zero level");

    // both stages full and output stalled: no new command may be taken
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && env.valid && !env.ready) |-> !cmd.ready)
        else $error("command taken while pipeline is full");

    // a transfer always lands in the command register
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> in_valid_reg)
        else $error("accepted command lost");
`endif

endmodule

`default_nettype wire
